// File: rtl/core/cvlc_pkg.sv
// cvlc_pkg: value kind and status codes, header constants and the range check
// for the compact vlc decoder
// depends on nothing; imported by compact_vlc_decoder and the testbench
package cvlc_pkg;

    localparam int unsigned MAX_PAYLOAD_BYTES = 8;
    localparam int unsigned VALUE_W           = 64;

    typedef enum logic [3:0] {
        KIND_BOOL     = 4'd0,
        KIND_U8       = 4'd1,
        KIND_U16      = 4'd2,
        KIND_U32      = 4'd3,
        KIND_U64      = 4'd4,
        KIND_I8       = 4'd5,
        KIND_I16      = 4'd6,
        KIND_I32      = 4'd7,
        KIND_I64      = 4'd8,
        KIND_PRESENCE = 4'd9
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_BOOL      = 3'd2,
        ST_PRESENCE  = 3'd3,
        ST_LENGTH    = 3'd4
    } status_t;

    // ones above the 7-bit and 14-bit short payloads
    localparam logic [VALUE_W-1:0] EXT7_MASK  = 64'hffff_ffff_ffff_ff80;
    localparam logic [VALUE_W-1:0] EXT14_MASK = 64'hffff_ffff_ffff_c000;

    function automatic logic kind_is_signed(input logic [3:0] kind);
        return (kind == KIND_I8) || (kind == KIND_I16) ||
               (kind == KIND_I32) || (kind == KIND_I64);
    endfunction

    // ones above the top byte of an n-byte long-form payload
    function automatic logic [VALUE_W-1:0] ext_mask(input logic [3:0] nbytes);
        logic [VALUE_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_PAYLOAD_BYTES; i++)
        begin
            if (4'(i) >= nbytes)
            begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    function automatic status_t range_check(input logic [3:0] kind,
                                            input logic [VALUE_W-1:0] v);
        status_t st;
        st = ST_OK;
        case (kind)
            KIND_BOOL:
            begin
                if (|v[63:8])
                    st = ST_RANGE;
                else if (|v[7:1])
                    st = ST_BOOL;
            end
            KIND_U8:  st = (|v[63:8])  ? ST_RANGE : ST_OK;
            KIND_U16: st = (|v[63:16]) ? ST_RANGE : ST_OK;
            KIND_U32: st = (|v[63:32]) ? ST_RANGE : ST_OK;
            // signed fit: everything from the sign bit up is all zeros or all ones
            KIND_I8:  st = ((&v[63:7])  || !(|v[63:7]))  ? ST_OK : ST_RANGE;
            KIND_I16: st = ((&v[63:15]) || !(|v[63:15])) ? ST_OK : ST_RANGE;
            KIND_I32: st = ((&v[63:31]) || !(|v[63:31])) ? ST_OK : ST_RANGE;
            KIND_PRESENCE: st = (v == 64'd1) ? ST_OK : ST_PRESENCE;
            default:  st = ST_OK;
        endcase
        return st;
    endfunction

endpackage

// File: rtl/core/compact_vlc_decoder.sv
// compact_vlc_decoder: byte-at-a-time decoder for compact binary variable-length values
// depends on cvlc_pkg for kind/status codes, header constants and the range check
//
// Takes one encoded byte per cycle on the input channel; a header byte also latches
// the value kind. Every accepted byte is decoded in a single pass of logic between the
// decoder state registers and the result register, so a completed value is offered on
// the output channel the cycle after its last byte is accepted. The sustained rate is
// one byte per cycle; in_ready drops only while a finished result sits unaccepted in
// the result register, which is the one buffering stage between the two sides.
module compact_vlc_decoder
    import cvlc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   byte_in,
    input  logic [3:0]   value_kind,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  value,
    output logic         is_null,
    output logic [2:0]   status
);

    logic         phase_reg, phase_next;
    logic [3:0]   bytes_left_reg, bytes_left_next;
    logic [3:0]   field_length_reg, field_length_next;
    logic [3:0]   kind_reg, kind_next;
    logic         short_form_reg, short_form_next;
    logic [63:0]  acc_reg, acc_next;

    logic         out_valid_reg;
    logic [63:0]  value_reg;
    logic         is_null_reg;
    status_t      status_reg;

    logic         in_fire;
    logic         emit;
    logic [63:0]  res_value;
    logic         res_null;
    status_t      res_status;
    logic         finish;
    logic [63:0]  fin_value;
    logic [2:0]   byte_idx;
    logic [63:0]  acc_merged;
    logic [3:0]   bytes_left_dec;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign byte_idx       = 3'(field_length_reg - bytes_left_reg);
    assign acc_merged     = acc_reg | ({56'd0, byte_in} << {byte_idx, 3'b000});
    assign bytes_left_dec = bytes_left_reg - 4'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        field_length_next = field_length_reg;
        kind_next         = kind_reg;
        short_form_next   = short_form_reg;
        acc_next          = acc_reg;
        emit              = 1'b0;
        res_value         = '0;
        res_null          = 1'b0;
        res_status        = ST_OK;
        finish            = 1'b0;
        fin_value         = '0;

        if (in_fire)
        begin
            if (!phase_reg)
            begin
                kind_next = value_kind;
                if (!byte_in[7])
                begin
                    // single-byte value, 7 bits
                    res_value = {57'd0, byte_in[6:0]};
                    if (kind_is_signed(value_kind) && byte_in[6])
                        res_value = res_value | EXT7_MASK;
                    res_status = range_check(value_kind, res_value);
                    emit       = 1'b1;
                end
                else if (!byte_in[6])
                begin
                    // two-byte short form, low 6 bits now
                    acc_next          = {58'd0, byte_in[5:0]};
                    short_form_next   = 1'b1;
                    field_length_next = 4'd1;
                    bytes_left_next   = 4'd1;
                    phase_next        = 1'b1;
                end
                else if (byte_in[5:0] == 6'd0)
                begin
                    res_null = 1'b1;
                    emit     = 1'b1;
                end
                else if (byte_in[5:0] > 6'(MAX_PAYLOAD_BYTES))
                begin
                    res_status = ST_LENGTH;
                    emit       = 1'b1;
                end
                else
                begin
                    field_length_next = byte_in[3:0];
                    bytes_left_next   = byte_in[3:0];
                    short_form_next   = 1'b0;
                    acc_next          = '0;
                    phase_next        = 1'b1;
                end
            end
            else if (short_form_reg)
            begin
                fin_value = acc_reg | {50'd0, byte_in, 6'd0};
                if (kind_is_signed(kind_reg) && byte_in[7])
                    fin_value = fin_value | EXT14_MASK;
                finish = 1'b1;
            end
            else if (bytes_left_dec != 4'd0)
            begin
                acc_next        = acc_merged;
                bytes_left_next = bytes_left_dec;
            end
            else
            begin
                // last payload byte carries the sign bit
                fin_value = acc_merged;
                if (kind_is_signed(kind_reg) && byte_in[7])
                    fin_value = fin_value | ext_mask(field_length_reg);
                finish = 1'b1;
            end

            if (finish)
            begin
                phase_next      = 1'b0;
                bytes_left_next = 4'd0;
                short_form_next = 1'b0;
                acc_next        = '0;
                res_value       = fin_value;
                res_status      = range_check(kind_reg, fin_value);
                emit            = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= 1'b0;
            bytes_left_reg   <= '0;
            field_length_reg <= '0;
            kind_reg         <= '0;
            short_form_reg   <= 1'b0;
            acc_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            field_length_reg <= field_length_next;
            kind_reg         <= kind_next;
            short_form_reg   <= short_form_next;
            acc_reg          <= acc_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded only when the slot is free or being emptied
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg   <= res_value;
            is_null_reg <= res_null;
            status_reg  <= res_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign is_null   = is_null_reg;
    assign status    = status_reg;

    // between values no payload bytes are outstanding
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_reg |-> (bytes_left_reg == 4'd0) && !short_form_reg && (acc_reg == 64'd0))
        else $error("decoder idle with payload state left over");

    a_count_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (bytes_left_reg != 4'd0) && (bytes_left_reg <= field_length_reg)
                      && (field_length_reg <= 4'(MAX_PAYLOAD_BYTES))
                      && (!short_form_reg || bytes_left_reg == 4'd1))
        else $error("payload byte count out of bounds");

    a_null_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_null_reg |-> (value_reg == 64'd0) && (status_reg == ST_OK))
        else $error("null transaction with non-zero value or status");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready)
        else $error("input stalled without a blocked result");

endmodule

// File: tb/sv/testbench.sv
// testbench: directed and random byte streams for compact_vlc_decoder, each result
// checked against a predictor of the header forms, sign extension and range checks
// depends on cvlc_pkg and rtl/core/compact_vlc_decoder.sv
module testbench;
    import cvlc_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_BYTES = 1200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 250;

    typedef struct {
        logic [7:0] data;
        logic [3:0] kind;
    } enc_byte_t;

    typedef struct {
        logic [63:0] val;
        logic        null_flag;
        status_t     st;
    } decoded_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic [7:0]  byte_in    = '0;
    logic [3:0]  value_kind = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [63:0] value;
    logic        is_null;
    logic [2:0]  status;

    enc_byte_t enc_stream[$];
    decoded_t  pending_values[$];
    int        errors     = 0;
    int        cycles     = 0;
    logic      byte_taken = 1'b0;

    // sender burst control
    int burst_left = 0;
    int gap_left   = 0;

    // receiver stall control
    int       rx_cycle  = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    rx_mode_t rx_mode   = RX_ALWAYS;

    // decoder state as seen by the predictor
    logic        in_payload = 1'b0;
    logic        two_byte   = 1'b0;
    logic [3:0]  left_cnt   = '0;
    logic [3:0]  len_cnt    = '0;
    logic [3:0]  held_kind  = '0;
    logic [63:0] acc        = '0;

    compact_vlc_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .value_kind (value_kind),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .value      (value),
        .is_null    (is_null),
        .status     (status)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic logic [63:0] sext(input logic [63:0] v, input int unsigned nbits);
        logic [63:0] keep;
        if (nbits == 0 || nbits >= 64)
            return v;
        keep = (64'd1 << nbits) - 64'd1;
        return v[nbits - 1] ? (v | ~keep) : v;
    endfunction

    function automatic logic fits_signed(input logic [63:0] v, input int unsigned nbits);
        logic [63:0] keep;
        keep = (64'd1 << nbits) - 64'd1;
        return sext(v & keep, nbits) == v;
    endfunction

    function automatic logic signed_kind(input logic [3:0] k);
        return (k >= KIND_I8) && (k <= KIND_I64);
    endfunction

    function automatic status_t kind_status(input logic [3:0] k, input logic [63:0] v);
        case (k)
            KIND_BOOL:
            begin
                if (v > 64'hff)
                    return ST_RANGE;
                return (v <= 64'd1) ? ST_OK : ST_BOOL;
            end
            KIND_U8:       return (v > 64'hff) ? ST_RANGE : ST_OK;
            KIND_U16:      return (v > 64'hffff) ? ST_RANGE : ST_OK;
            KIND_U32:      return (v > 64'hffff_ffff) ? ST_RANGE : ST_OK;
            KIND_I8:       return fits_signed(v, 8) ? ST_OK : ST_RANGE;
            KIND_I16:      return fits_signed(v, 16) ? ST_OK : ST_RANGE;
            KIND_I32:      return fits_signed(v, 32) ? ST_OK : ST_RANGE;
            KIND_PRESENCE: return (v == 64'd1) ? ST_OK : ST_PRESENCE;
            default:       return ST_OK;
        endcase
    endfunction

    task automatic note_result(input logic [63:0] v, input logic nul, input status_t st);
        decoded_t d;
        d.val       = v;
        d.null_flag = nul;
        d.st        = st;
        pending_values.push_back(d);
    endtask

    // advance the predicted decoder by one accepted byte
    task automatic predict_byte(input logic [7:0] b, input logic [3:0] k);
        logic [63:0] v;
        logic        done;
        int          sh;
        v    = '0;
        done = 1'b0;
        if (!in_payload)
        begin
            held_kind = k;
            if (b < 8'h80)
            begin
                v = {57'd0, b[6:0]};
                if (signed_kind(held_kind))
                    v = sext(v, 7);
                done = 1'b1;
            end
            else if (b < 8'hc0)
            begin
                acc        = {58'd0, b[5:0]};
                two_byte   = 1'b1;
                len_cnt    = 4'd1;
                left_cnt   = 4'd1;
                in_payload = 1'b1;
            end
            else if (b == 8'hc0)
            begin
                note_result('0, 1'b1, ST_OK);
            end
            else if (b[5:0] > MAX_PAYLOAD_BYTES)
            begin
                note_result('0, 1'b0, ST_LENGTH);
            end
            else
            begin
                len_cnt    = b[3:0];
                left_cnt   = b[3:0];
                two_byte   = 1'b0;
                acc        = '0;
                in_payload = 1'b1;
            end
        end
        else if (two_byte)
        begin
            v = acc | ({56'd0, b} << 6);
            if (signed_kind(held_kind))
                v = sext(v, 14);
            done = 1'b1;
        end
        else
        begin
            // little-endian: first payload byte lands lowest
            sh       = 8 * int'((len_cnt - left_cnt) & 4'd7);
            acc      = acc | ({56'd0, b} << sh);
            left_cnt = left_cnt - 4'd1;
            if (left_cnt == 4'd0)
            begin
                v = acc;
                if (signed_kind(held_kind))
                    v = sext(v, 8 * int'(len_cnt));
                done = 1'b1;
            end
        end
        if (done)
        begin
            in_payload = 1'b0;
            two_byte   = 1'b0;
            left_cnt   = '0;
            acc        = '0;
            note_result(v, 1'b0, kind_status(held_kind, v));
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic [3:0] k);
        enc_byte_t e;
        e.data = b;
        e.kind = k;
        enc_stream.push_back(e);
    endtask

    // one encoded value, mostly well formed, sometimes null or an oversize length
    task automatic add_random_value();
        logic [3:0] k;
        logic [7:0] fill;
        int         form;
        int         n;
        int         sig;
        if ($urandom_range(0, 15) == 0)
            k = 4'($urandom_range(10, 15));
        else
            k = 4'($urandom_range(0, 9));
        form = $urandom_range(0, 99);
        if (form < 30)
        begin
            add_byte(8'($urandom_range(0, 127)), k);
        end
        else if (form < 55)
        begin
            add_byte(8'h80 | 8'($urandom_range(0, 63)), k);
            add_byte(8'($urandom), 4'($urandom));
        end
        else if (form < 88)
        begin
            n    = $urandom_range(1, MAX_PAYLOAD_BYTES);
            sig  = $urandom_range(0, 1) ? n : $urandom_range(1, n);
            fill = $urandom_range(0, 1) ? 8'hff : 8'h00;
            add_byte(8'hc0 | 8'(n), k);
            // bytes above the significant ones are all zeros or all ones, so range checks can pass
            for (int i = 0; i < n; i++)
                add_byte((i < sig) ? 8'($urandom) : fill, 4'($urandom));
        end
        else if (form < 94)
        begin
            add_byte(8'hc0, k);
        end
        else
        begin
            add_byte(8'hc0 | 8'($urandom_range(MAX_PAYLOAD_BYTES + 1, 63)), k);
        end
    endtask

    // driver: offers bytes in bursts, payload held until the transaction completes
    always @(negedge clk)
    begin : driver
        enc_byte_t nxt;
        if (rst_n && (!in_valid || byte_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (enc_stream.size() > 0)
            begin
                nxt = enc_stream.pop_front();
                in_valid   <= 1'b1;
                byte_in    <= nxt.data;
                value_kind <= nxt.kind;
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern changes at random over the run, plus two long hold-offs
    always @(negedge clk)
    begin : receiver
        rx_cycle = rx_cycle + 1;
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (rx_cycle == 600 || rx_cycle == 1800)
        begin
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end
            else
            begin
                mode_left = mode_left - 1;
            end
            case (rx_mode)
                RX_ALWAYS:   out_ready <= 1'b1;
                RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
                RX_PERIODIC: out_ready <= (rx_cycle % 4 != 0);
                default:     out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // monitor: predict on input transactions, check on output transactions
    always @(posedge clk)
    begin : monitor
        decoded_t want;
        if (rst_n)
        begin
            byte_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
                predict_byte(byte_in, value_kind);
            if (out_valid && out_ready)
            begin
                if (pending_values.size() == 0)
                begin
                    $display("%0t: unexpected result: value %h is_null %b status %0d",
                             $time, value, is_null, status);
                    errors = errors + 1;
                end
                else
                begin
                    want = pending_values.pop_front();
                    if (value !== want.val)
                    begin
                        $display("%0t: value mismatch: expected %h actual %h",
                                 $time, want.val, value);
                        errors = errors + 1;
                    end
                    if (is_null !== want.null_flag)
                    begin
                        $display("%0t: is_null mismatch: expected %b actual %b",
                                 $time, want.null_flag, is_null);
                        errors = errors + 1;
                    end
                    if (status !== want.st)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.st, status);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        int queued;
        // short form sign extension, bad presence, bool not 0/1, null, oversize length
        add_byte(8'h7f, KIND_I8);
        add_byte(8'h00, KIND_PRESENCE);
        add_byte(8'h02, KIND_BOOL);
        add_byte(8'hc0, KIND_PRESENCE);
        add_byte(8'hc9, KIND_U8);
        // two-byte form: -1 as i16, then a u8 out of range
        add_byte(8'hbf, KIND_I16);
        add_byte(8'hff, KIND_U8);
        add_byte(8'h80, KIND_U8);
        add_byte(8'hff, KIND_I64);
        // one-byte long form fully sign-extended
        add_byte(8'hc1, KIND_I8);
        add_byte(8'h80, KIND_U8);
        // bool above 255
        add_byte(8'hc2, KIND_BOOL);
        add_byte(8'h00, KIND_I8);
        add_byte(8'h01, KIND_I8);
        // eight-byte payload, all ones
        add_byte(8'hc8, KIND_I64);
        for (int i = 0; i < MAX_PAYLOAD_BYTES; i++)
            add_byte(8'hff, 4'hf);
        // kind with no meaning, largest length code, presence present
        add_byte(8'h7f, 4'hf);
        add_byte(8'hff, KIND_U64);
        add_byte(8'h01, KIND_PRESENCE);

        queued = enc_stream.size();
        while (enc_stream.size() < queued + RANDOM_BYTES)
            add_random_value();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (enc_stream.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: compact_vlc_decoder.f
rtl/core/cvlc_pkg.sv
rtl/core/compact_vlc_decoder.sv
tb/sv/testbench.sv
